// ----- rtl/core/bpad_pkg.sv -----
// package for the block power average meter
// shared widths, decibel table and the divider status struct; no dependencies
package bpad_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_BLOCK_DEF   = 16384;

    localparam int MEAN_W   = 32;
    localparam int DB_W     = 15;
    localparam int BLKNUM_W = 32;
    localparam int SCNT_W   = 15;
    localparam int EXP_W    = 6;
    localparam int MANT_W   = 6;
    localparam int DBF_W    = 17;
    localparam int SUM_MAX_W = 64;

    localparam logic [DBF_W-1:0] DB_PER_OCTAVE = 17'd771;
    localparam logic [DBF_W-1:0] DB_MAX        = 17'd32767;

    // round(2560*log10(1+m/64))
    localparam logic [9:0] FRAC_DB [0:63] = '{
        10'd0,   10'd17,  10'd34,  10'd51,  10'd67,  10'd84,  10'd100, 10'd115,
        10'd131, 10'd146, 10'd161, 10'd176, 10'd191, 10'd206, 10'd220, 10'd234,
        10'd248, 10'd262, 10'd276, 10'd289, 10'd302, 10'd315, 10'd328, 10'd341,
        10'd354, 10'd367, 10'd379, 10'd391, 10'd403, 10'd415, 10'd427, 10'd439,
        10'd451, 10'd462, 10'd474, 10'd485, 10'd496, 10'd507, 10'd518, 10'd529,
        10'd540, 10'd550, 10'd561, 10'd571, 10'd582, 10'd592, 10'd602, 10'd612,
        10'd622, 10'd632, 10'd642, 10'd652, 10'd661, 10'd671, 10'd680, 10'd690,
        10'd699, 10'd708, 10'd717, 10'd726, 10'd735, 10'd744, 10'd753, 10'd762
    };

    typedef struct packed {
        logic              done;
        logic              nonzero;
        logic [EXP_W-1:0]  exp;
        logic [MANT_W-1:0] mant;
    } t_div_stat;

endpackage

// ----- rtl/core/bpad_if.sv -----
// valid/ready channel interfaces for the block power average meter
// depends on bpad_pkg for payload widths
interface bpad_in_if #(
    parameter int SAMPLE_BITS = bpad_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic                          last_sample;

    modport source (output valid, output sample_i, output sample_q, output last_sample,
                    input ready);
    modport sink   (input valid, input sample_i, input sample_q, input last_sample,
                    output ready);
endinterface

interface bpad_out_if;
    logic                          valid;
    logic                          ready;
    logic [bpad_pkg::MEAN_W-1:0]   mean_power;
    logic [bpad_pkg::DB_W-1:0]     power_db;
    logic                          zero_power;
    logic [bpad_pkg::BLKNUM_W-1:0] block_number;
    logic [bpad_pkg::SCNT_W-1:0]   sample_count;

    modport source (output valid, output mean_power, output power_db, output zero_power,
                    output block_number, output sample_count, input ready);
    modport sink   (input valid, input mean_power, input power_db, input zero_power,
                    input block_number, input sample_count, output ready);
endinterface

// ----- rtl/core/bpad_divlog.sv -----
// restoring divider, one quotient bit per cycle, msb first
// also captures the leading-one position and the six bits below it; uses bpad_pkg
module bpad_divlog #(
    parameter int SUM_W = 48,
    parameter int CNT_W = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SUM_W-1:0]           i_dividend,
    input  logic [CNT_W-1:0]           i_divisor,
    output logic [SUM_W-1:0]           o_quotient,
    output bpad_pkg::t_div_stat        o_stat
);

    localparam int BIT_W = $clog2(SUM_W);

    logic [SUM_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_div;
    logic [BIT_W-1:0]          r_bit;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_seen;
    logic [BIT_W-1:0]          r_exp;
    logic [bpad_pkg::MANT_W-1:0] r_m;
    logic [2:0]                r_mk;

    logic [CNT_W:0]   remsh;
    logic [CNT_W:0]   diff;
    logic             qbit;
    logic [CNT_W-1:0] n_rem;

    assign remsh = {r_rem, r_quo[SUM_W-1]};
    assign diff  = remsh - {1'b0, r_div};
    assign qbit  = (remsh >= {1'b0, r_div});
    assign n_rem = qbit ? diff[CNT_W-1:0] : remsh[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_bit == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_bit  <= BIT_W'(SUM_W - 1);
            r_seen <= 1'b0;
            r_exp  <= '0;
            r_m    <= '0;
            r_mk   <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], qbit};
            r_rem <= n_rem;
            r_bit <= r_bit - 1'b1;
            if (qbit && !r_seen) begin
                r_seen <= 1'b1;
                r_exp  <= r_bit;
            end else if (r_seen && r_mk < 3'd6) begin
                r_m  <= {r_m[bpad_pkg::MANT_W-2:0], qbit};
                r_mk <= r_mk + 1'b1;
            end
        end
    end

    // pad with zeros when fewer than six bits follow the leading one
    assign o_quotient     = r_quo;
    assign o_stat.done    = r_done;
    assign o_stat.nonzero = r_seen;
    assign o_stat.exp     = bpad_pkg::EXP_W'(r_exp);
    assign o_stat.mant    = r_m << (3'd6 - r_mk);

endmodule

// ----- rtl/core/block_power_average_db.sv -----
// block power average meter with decibel readout, top level
// uses bpad_pkg, bpad_in_if / bpad_out_if and bpad_divlog
//
// i_in carries one complex sample per item plus a last-of-block flag; o_out
// carries one result per closed block: floor(sum/count) of I*I+Q*Q, the mean
// in 1/256 dB, a zero-power flag, the block index and the sample count.
// a block also closes on the sample that brings its count to MAX_BLOCK.
// each sample passes through accept, square I, square Q and accumulate, all on
// one shared multiplier, so i_in.ready is low from the accept to the accumulate.
// a closing sample then starts the divider, which takes one quotient bit at a
// time over the SUM_W-bit sum (48 bits at default parameters) while i_in.ready
// stays low; the result is then loaded into the output register.
// the output register holds a result until o_out.ready; samples keep being
// accepted meanwhile up to the next closing sample, which stalls i_in until then.
// reset (synchronous, active low) clears the sum, count and block index and
// drops o_out.valid.
module block_power_average_db #(
    parameter int MAX_BLOCK   = bpad_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = bpad_pkg::SAMPLE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bpad_in_if.sink    i_in,
    bpad_out_if.source o_out
);

    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int FULL_W = 2 * SAMPLE_BITS + 1 + CNT_W;
    localparam int SUM_W  = (FULL_W > bpad_pkg::SUM_MAX_W) ? bpad_pkg::SUM_MAX_W : FULL_W;
    localparam int PROD_W = 2 * SAMPLE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_I = 3'd1;
    localparam logic [2:0] S_MUL_Q = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]             r_state;
    logic [SAMPLE_BITS-1:0] r_mag_i;
    logic [SAMPLE_BITS-1:0] r_mag_q;
    logic                   r_last;
    logic [PROD_W-1:0]      r_prod;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_res_cnt;
    logic [bpad_pkg::BLKNUM_W-1:0] r_blocks;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] n_mag_i;
    logic [SAMPLE_BITS-1:0] n_mag_q;
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [PROD_W-1:0]      n_prod;
    logic [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]       n_count;
    logic                   close_blk;
    logic                   div_start;
    logic                   in_acc;
    logic                   out_free;
    logic                   load_out;
    logic [SUM_W-1:0]       quotient;
    bpad_pkg::t_div_stat    div_stat;
    logic [bpad_pkg::DBF_W-1:0]  db_full;
    logic [bpad_pkg::DB_W-1:0]   db_sat;
    logic [bpad_pkg::MEAN_W-1:0] mean_sat;

    assign n_mag_i = i_in.sample_i[SAMPLE_BITS-1] ? (~i_in.sample_i + 1'b1) : i_in.sample_i;
    assign n_mag_q = i_in.sample_q[SAMPLE_BITS-1] ? (~i_in.sample_q + 1'b1) : i_in.sample_q;

    // the one multiplier, shared between the two squares
    assign mul_a  = (r_state == S_MUL_I) ? r_mag_i : r_mag_q;
    assign n_prod = mul_a * mul_a;
    assign n_sum  = r_sum + SUM_W'(r_prod);

    assign n_count   = r_count + 1'b1;
    assign close_blk = r_last || (n_count == CNT_W'(MAX_BLOCK));
    assign div_start = (r_state == S_ACC) && close_blk;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign load_out   = (r_state == S_DIV) && div_stat.done && out_free;

    bpad_divlog #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divlog (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    always_comb begin
        db_full = bpad_pkg::DBF_W'(div_stat.exp) * bpad_pkg::DB_PER_OCTAVE
                + bpad_pkg::DBF_W'(bpad_pkg::FRAC_DB[div_stat.mant]);
        if (!div_stat.nonzero) begin
            db_sat = '0;
        end else if (db_full > bpad_pkg::DB_MAX) begin
            db_sat = bpad_pkg::DB_MAX[bpad_pkg::DB_W-1:0];
        end else begin
            db_sat = db_full[bpad_pkg::DB_W-1:0];
        end
        // only wide parameter sets can push the mean past 32 bits
        if ((quotient >> bpad_pkg::MEAN_W) != '0) begin
            mean_sat = '1;
        end else begin
            mean_sat = bpad_pkg::MEAN_W'(quotient);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_count  <= '0;
            r_blocks <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL_I;
                    end
                end
                S_MUL_I: begin
                    r_state <= S_MUL_Q;
                end
                S_MUL_Q: begin
                    r_sum   <= n_sum;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (close_blk) begin
                        r_sum   <= '0;
                        r_count <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (load_out) begin
                        r_blocks <= r_blocks + 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag_i <= n_mag_i;
            r_mag_q <= n_mag_q;
            r_last  <= i_in.last_sample;
        end
        if (r_state == S_MUL_I || r_state == S_MUL_Q) begin
            r_prod <= n_prod;
        end
        if (div_start) begin
            r_res_cnt <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out.mean_power   <= mean_sat;
            o_out.power_db     <= db_sat;
            o_out.zero_power   <= !div_stat.nonzero;
            o_out.block_number <= r_blocks;
            o_out.sample_count <= bpad_pkg::SCNT_W'(r_res_cnt);
        end
    end

    assign o_out.valid = r_out_valid;

    // the open block never holds a full count
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_BLOCK))
        else $error("open block count reached MAX_BLOCK");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> div_stat.done && $past(r_state) == S_DIV)
        else $error("result loaded before the divider finished");

    a_zero_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_power) |-> (o_out.mean_power == '0 && o_out.power_db == '0))
        else $error("zero power flag disagrees with the mean");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_MUL_I)
        else $error("accepted item did not start the square sequence");

endmodule
